FILE: sv/sitp_pkg.sv
// shared types and constants for the signed integer text parser
`default_nettype none
package sitp_pkg;

   localparam int unsigned CharWidth  = 8;
   localparam int unsigned ValueWidth = 64;
   localparam int unsigned DigitWidth = 4;

   typedef enum logic [1:0] {
      ST_NUMBER      = 2'd0,
      ST_NO_NUMBER   = 2'd1,
      ST_SIGN_ONLY   = 2'd2,
      ST_PREFIX_ONLY = 2'd3
   } status_type;

   typedef enum logic {
      CSR_HEX_PREFIX_ENABLE = 1'b0,
      CSR_SIGN_ENABLE       = 1'b1
   } csr_index_type;

   localparam logic [CharWidth-1:0] CharZero   = 8'h30;
   localparam logic [CharWidth-1:0] CharNine   = 8'h39;
   localparam logic [CharWidth-1:0] CharLowerA = 8'h61;
   localparam logic [CharWidth-1:0] CharLowerF = 8'h66;
   localparam logic [CharWidth-1:0] CharUpperA = 8'h41;
   localparam logic [CharWidth-1:0] CharUpperF = 8'h46;
   localparam logic [CharWidth-1:0] CharLowerX = 8'h78;
   localparam logic [CharWidth-1:0] CharUpperX = 8'h58;
   localparam logic [CharWidth-1:0] CharPlus   = 8'h2b;
   localparam logic [CharWidth-1:0] CharMinus  = 8'h2d;

   localparam logic [ValueWidth-1:0] PosLimit = {1'b0, {(ValueWidth-1){1'b1}}};
   localparam logic [ValueWidth-1:0] NegLimit = {1'b1, {(ValueWidth-1){1'b0}}};

   typedef struct packed {
      logic                         emit;
      status_type                   status;
      logic signed [ValueWidth-1:0] value;
      logic                         overflow;
      logic                         was_hex;
      logic [CharWidth-1:0]         stop_char;
      logic                         stop_at_end;
   } result_type;

endpackage
`default_nettype wire

FILE: sv/sitp_if.sv
// channel interfaces: character requests, parse results, register writes
`default_nettype none
interface sitp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       end_of_text;

   modport source (output valid, output char_code, output end_of_text, input ready);
   modport sink (input valid, input char_code, input end_of_text, output ready);
endinterface

interface sitp_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic signed [63:0] value;
   logic               overflow;
   logic               was_hex;
   logic [7:0]         stop_char;
   logic               stop_at_end;

   modport source (output valid, output status, output value, output overflow,
                   output was_hex, output stop_char, output stop_at_end, input ready);
   modport sink (input valid, input status, input value, input overflow,
                 input was_hex, input stop_char, input stop_at_end, output ready);
endinterface

interface sitp_csr_if;
   logic valid;
   logic ready;
   logic index;
   logic data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: sv/sitp_core.sv
// parse state machine: one character step per cycle while step is high, with multiply-add accumulation
`default_nettype none
module sitp_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          step,
   input  wire logic [sitp_pkg::CharWidth-1:0] char_code,
   input  wire logic                          end_of_text,
   input  wire logic                          hex_prefix_enable,
   input  wire logic                          sign_enable,
   output sitp_pkg::result_type               result
);
   import sitp_pkg::*;

   typedef enum logic [2:0] {
      PH_START   = 3'd0,
      PH_SIGNED  = 3'd1,
      PH_ZERO    = 3'd2,
      PH_XPREFIX = 3'd3,
      PH_HEX     = 3'd4,
      PH_DEC     = 3'd5
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic                   negative_ff, negative_in;
   logic [ValueWidth-1:0]  magnitude_ff, magnitude_in;
   logic                   overflowed_ff, overflowed_in;
   logic                   had_sign_ff, had_sign_in;

   logic                   is_dec, is_hex, is_x, is_sign, is_zero;
   logic [DigitWidth-1:0]  dec_digit, hex_digit;
   logic [ValueWidth+3:0]  sum10;
   logic [ValueWidth-1:0]  next10, next16;
   logic                   ovf10, ovf16;
   logic                   emit;
   status_type             emit_status;
   logic                   num_ovf;
   logic [ValueWidth-1:0]  num_value;
   logic                   cur_hex;

   // character classes
   always_comb begin
      is_dec    = (char_code >= CharZero) && (char_code <= CharNine);
      dec_digit = DigitWidth'(char_code - CharZero);
      is_hex    = 1'b1;
      hex_digit = dec_digit;
      priority if (is_dec) begin
         hex_digit = dec_digit;
      end else if ((char_code >= CharLowerA) && (char_code <= CharLowerF)) begin
         hex_digit = DigitWidth'(char_code - CharLowerA + 8'd10);
      end else if ((char_code >= CharUpperA) && (char_code <= CharUpperF)) begin
         hex_digit = DigitWidth'(char_code - CharUpperA + 8'd10);
      end else begin
         is_hex = 1'b0;
      end
      is_x    = (char_code == CharLowerX) || (char_code == CharUpperX);
      is_sign = (char_code == CharPlus) || (char_code == CharMinus);
      is_zero = (char_code == CharZero);
   end

   // multiply-add by ten and by sixteen
   always_comb begin
      sum10  = ({4'd0, magnitude_ff} << 3) + ({4'd0, magnitude_ff} << 1)
               + {{ValueWidth{1'b0}}, dec_digit};
      next10 = sum10[ValueWidth-1:0];
      ovf10  = |sum10[ValueWidth+3:ValueWidth];
      next16 = {magnitude_ff[ValueWidth-DigitWidth-1:0], hex_digit};
      ovf16  = |magnitude_ff[ValueWidth-1:ValueWidth-DigitWidth];
   end

   // number as it stands before this character
   always_comb begin
      num_ovf   = overflowed_ff || (magnitude_ff > (negative_ff ? NegLimit : PosLimit));
      num_value = negative_ff ? (~magnitude_ff + 1'b1) : magnitude_ff;
      cur_hex   = (phase_ff == PH_XPREFIX) || (phase_ff == PH_HEX);
   end

   always_comb begin
      phase_in      = phase_ff;
      negative_in   = negative_ff;
      magnitude_in  = magnitude_ff;
      overflowed_in = overflowed_ff;
      had_sign_in   = had_sign_ff;
      emit          = 1'b0;
      emit_status   = ST_NUMBER;
      unique case (phase_ff)
         PH_ZERO: begin
            if (end_of_text) begin
               emit = 1'b1;
            end else if (hex_prefix_enable && is_x) begin
               phase_in = PH_XPREFIX;
            end else if (is_dec) begin
               magnitude_in  = next10;
               overflowed_in = overflowed_ff | ovf10;
               phase_in      = PH_DEC;
            end else begin
               emit = 1'b1;
            end
         end
         PH_XPREFIX, PH_HEX: begin
            emit_status = (phase_ff == PH_HEX) ? ST_NUMBER : ST_PREFIX_ONLY;
            if (!end_of_text && is_hex) begin
               magnitude_in  = next16;
               overflowed_in = overflowed_ff | ovf16;
               phase_in      = PH_HEX;
            end else begin
               emit = 1'b1;
            end
         end
         PH_DEC: begin
            if (!end_of_text && is_dec) begin
               magnitude_in  = next10;
               overflowed_in = overflowed_ff | ovf10;
            end else begin
               emit = 1'b1;
            end
         end
         default: begin
            // start, after a sign, and unused codes
            emit_status = had_sign_ff ? ST_SIGN_ONLY : ST_NO_NUMBER;
            if (end_of_text) begin
               emit = 1'b1;
            end else if ((phase_ff != PH_SIGNED) && sign_enable && is_sign) begin
               negative_in = (char_code == CharMinus);
               had_sign_in = 1'b1;
               phase_in    = PH_SIGNED;
            end else if (is_zero) begin
               phase_in = PH_ZERO;
            end else if (is_dec) begin
               magnitude_in  = next10;
               overflowed_in = overflowed_ff | ovf10;
               phase_in      = PH_DEC;
            end else begin
               emit = 1'b1;
            end
         end
      endcase
      if (emit) begin
         phase_in      = PH_START;
         negative_in   = 1'b0;
         magnitude_in  = '0;
         overflowed_in = 1'b0;
         had_sign_in   = 1'b0;
      end
   end

   always_comb begin
      result.emit        = emit;
      result.status      = emit_status;
      result.value       = (emit_status == ST_NUMBER) ? num_value : '0;
      result.overflow    = (emit_status == ST_NUMBER) ? num_ovf : 1'b0;
      result.was_hex     = cur_hex;
      result.stop_char   = end_of_text ? '0 : char_code;
      result.stop_at_end = end_of_text;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_START;
         negative_ff   <= 1'b0;
         magnitude_ff  <= '0;
         overflowed_ff <= 1'b0;
         had_sign_ff   <= 1'b0;
      end else if (step) begin
         phase_ff      <= phase_in;
         negative_ff   <= negative_in;
         magnitude_ff  <= magnitude_in;
         overflowed_ff <= overflowed_in;
         had_sign_ff   <= had_sign_in;
      end
   end

endmodule
`default_nettype wire

FILE: sv/signed_integer_text_parser_unit.sv
// top level of the signed integer text parser
//
//   channel   dir   payload                                              transaction
//   req_chan  in    char_code, end_of_text                               valid & ready
//   rsp_chan  out   status, value, overflow, was_hex, stop_char, end     valid & ready
//   csr_chan  in    index, data (0 hex_prefix_enable, 1 sign_enable)     valid & ready
//
// one character per cycle while the result is not stalled; the character that ends the number
// passes through the input register, then the step logic into the result register
// the step logic is one 68-bit multiply-add by ten or a 64-bit shift-in by sixteen plus the final negate
// synchronous reset returns to the start of a number with both options enabled
// a stalled result holds the step stage; the input register takes one more character only while it is empty
`default_nettype none
module signed_integer_text_parser_unit (
   input wire logic    clock,
   input wire logic    reset,
   sitp_req_if.sink    req_chan,
   sitp_rsp_if.source  rsp_chan,
   sitp_csr_if.sink    csr_chan
);
   import sitp_pkg::*;

   logic                  in_valid_ff, in_valid_in;
   logic [CharWidth-1:0]  char_ff;
   logic                  end_ff;
   logic                  hex_enable_ff;
   logic                  sign_enable_ff;
   logic                  out_valid_ff, out_valid_in;
   result_type            out_ff;
   result_type            step_result;
   logic                  advance;
   logic                  req_take;

   assign advance  = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_take = req_chan.valid && req_chan.ready;

   assign req_chan.ready = !in_valid_ff || advance;
   assign csr_chan.ready = 1'b1;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = (advance && step_result.emit) || (out_valid_ff && !rsp_chan.ready);

   sitp_core u_core (
      .clock             (clock),
      .reset             (reset),
      .step              (advance),
      .char_code         (char_ff),
      .end_of_text       (end_ff),
      .hex_prefix_enable (hex_enable_ff),
      .sign_enable       (sign_enable_ff),
      .result            (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         hex_enable_ff  <= 1'b1;
         sign_enable_ff <= 1'b1;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_chan.valid) begin
            unique case (csr_index_type'(csr_chan.index))
               CSR_HEX_PREFIX_ENABLE: hex_enable_ff  <= csr_chan.data;
               CSR_SIGN_ENABLE:       sign_enable_ff <= csr_chan.data;
               default:               hex_enable_ff  <= hex_enable_ff;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         char_ff <= req_chan.char_code;
         end_ff  <= req_chan.end_of_text;
      end
      if (advance && step_result.emit) begin
         out_ff <= step_result;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.status      = out_ff.status;
   assign rsp_chan.value       = out_ff.value;
   assign rsp_chan.overflow    = out_ff.overflow;
   assign rsp_chan.was_hex     = out_ff.was_hex;
   assign rsp_chan.stop_char   = out_ff.stop_char;
   assign rsp_chan.stop_at_end = out_ff.stop_at_end;

endmodule
`default_nettype wire
